@@ rtl/ccvc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the coverage-cap visibility cull.
// No dependencies; imported by every module of the block.

package ccvc_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int DSI_FRAC  = 24;

    // Field and register widths
    localparam int COORD_W    = 32;
    localparam int ER_W       = 30;
    localparam int DSI_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ER_W-1:0]  EARTH_RESET = 30'd417529856;
    localparam logic [DSI_W-1:0] DSI_RESET   = 32'd16777;

    // Square root unit: 64-bit radicand, one root bit per stage
    localparam int SQ_IN_W  = 64;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQRT_LAT = SQ_OUT_W;

    // Divider: one quotient bit per stage, quotient known below 2^(FRAC_BITS+1)
    localparam int DIV_N_W = 57;
    localparam int DIV_D_W = 41;
    localparam int DIV_Q_W = FRAC_BITS + 1;
    localparam int DIV_LAT = DIV_Q_W;

    // Unit-vector unit
    localparam int VEC_W    = 41;
    localparam int NORM_W   = 30;
    localparam int UNIT_W   = FRAC_BITS + 2;
    localparam int UNIT_LAT = 4 + SQRT_LAT + DIV_LAT + 1;

    // Derived earth and satellite distances in draw units
    localparam int ED_W = ER_W + DSI_W - DSI_FRAC;
    localparam int RD_W = SQ_OUT_W + DSI_W - DSI_FRAC;

    // Start-to-done latency of the whole block
    localparam int LATENCY = 2 * UNIT_LAT + 5;

    typedef enum logic
    {
        REG_EARTH = 1'b0,
        REG_DSI   = 1'b1
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [VEC_W-1:0]   vec_comp_t;
    typedef logic signed [UNIT_W-1:0]  unit_comp_t;

endpackage

@@ rtl/coverage_cap_visibility_cull.sv @@
`timescale 1ns / 1ps
// Top level of the coverage-cap visibility cull: APB registers and the main pipeline.
// Depends on ccvc_pkg, ccvc_isqrt, ccvc_div, ccvc_unit.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-----------------------------------------
//  item in  | start (taken when busy is low)  | sat_active, sat_*, cam_*, look_*
//  result   | done, one-cycle strobe          | visible
//  config   | APB psel/penable/pwrite, pready | paddr, pwdata / prdata
//
// Throughput is one transfer per clock; busy is never raised since nothing
// downstream can push back. The path from start to done runs through the chain:
// input register, unit vector of the satellite, sub-point multiply and camera
// subtract, unit vector toward the sub-point, dot product (2 stages) and the
// compare. The |sat| root and r_draw and the cos/sin branch (divider, square
// root) run beside it and finish early.
// rst_n is asynchronous, clears the valid pipeline and loads the config registers
// with their reset values; no clearing pass is needed. The receiver cannot stall:
// each result shows for exactly one cycle.

module coverage_cap_visibility_cull (
    input  logic                           clk,
    input  logic                           rst_n,
    // item channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           sat_active,
    input  logic signed [31:0]             sat_x,
    input  logic signed [31:0]             sat_y,
    input  logic signed [31:0]             sat_z,
    input  logic signed [31:0]             cam_x,
    input  logic signed [31:0]             cam_y,
    input  logic signed [31:0]             cam_z,
    input  logic signed [31:0]             look_x,
    input  logic signed [31:0]             look_y,
    input  logic signed [31:0]             look_z,
    // result channel
    output logic                           done,
    output logic                           visible,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccvc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ccvc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ccvc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ccvc_pkg::*;

    // pipeline ranks, counted in registers after the input register
    localparam int T_SUM   = 2;
    localparam int T_RKM   = T_SUM + SQRT_LAT;
    localparam int T_RDRAW = T_RKM + 1;
    localparam int T_UB    = 1 + UNIT_LAT;
    localparam int T_PROD  = UNIT_LAT + 1;
    localparam int T_TOSUB = T_PROD + 1;
    localparam int T_UA    = T_TOSUB + UNIT_LAT;
    localparam int T_DOT   = T_UA + 2;
    localparam int T_SIN   = T_RDRAW + DIV_LAT + 3 + SQRT_LAT;

    localparam int ACT_DLY = T_RDRAW;
    localparam int OK_DLY  = T_DOT - T_RDRAW;
    localparam int CAM_DLY = T_PROD;
    localparam int UB_DLY  = T_UA - T_UB;
    localparam int SIN_DLY = T_DOT - T_SIN;

    localparam int SIN_W = FRAC_BITS + 1;
    localparam int COS2_W = 2 * DIV_Q_W;
    localparam int PROD_W = ED_W + 1 + UNIT_W;
    localparam int MUL_W  = 2 * UNIT_W;
    localparam int DOT_W  = MUL_W + 2;
    localparam int CMP_W  = DOT_W + 2;

    localparam logic [DIV_Q_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ER_W-1:0]  earth_reg;
    logic [DSI_W-1:0] dsi_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            earth_reg <= EARTH_RESET;
            dsi_reg   <= DSI_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_EARTH: earth_reg <= pwdata[ER_W-1:0];
                REG_DSI:   dsi_reg   <= pwdata[DSI_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_EARTH: prdata = CFG_DATA_W'(earth_reg);
            REG_DSI:   prdata = CFG_DATA_W'(dsi_reg);
            default:   prdata = '0;
        endcase
    end

    // Earth radius in draw units; the user must make config changes only while idle; the block does not enforce it
    logic [ER_W+DSI_W-1:0] ed_prod;
    logic [ED_W-1:0]       erad_du_reg;

    assign ed_prod = (ER_W+DSI_W)'(earth_reg) * (ER_W+DSI_W)'(dsi_reg);

    always_ff @(posedge clk)
    begin
        erad_du_reg <= ed_prod[ER_W+DSI_W-1:DSI_FRAC];
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic   v0_reg;
    logic   act0_reg;
    coord_t sat0_reg  [3];
    coord_t cam0_reg  [3];
    coord_t look0_reg [3];

    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        act0_reg     <= sat_active;
        sat0_reg[0]  <= sat_x;
        sat0_reg[1]  <= sat_y;
        sat0_reg[2]  <= sat_z;
        cam0_reg[0]  <= cam_x;
        cam0_reg[1]  <= cam_y;
        cam0_reg[2]  <= cam_z;
        look0_reg[0] <= look_x;
        look0_reg[1] <= look_y;
        look0_reg[2] <= look_z;
    end

    // ------------------------------------------------------------------
    // |sat| in km: squares, sum, square root
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]   smag [3];
    logic [2*COORD_W-1:0] sq1_reg [3];
    vec_comp_t            tolook1_reg [3];
    logic [SQ_IN_W-1:0]   sum2_reg;
    logic                 v1_reg;
    logic                 v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            smag[i] = sat0_reg[i][COORD_W-1] ? COORD_W'(-sat0_reg[i])
                                              : COORD_W'(sat0_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq1_reg[i]     <= {{COORD_W{1'b0}}, smag[i]} * {{COORD_W{1'b0}}, smag[i]};
            tolook1_reg[i] <= VEC_W'(look0_reg[i]) - VEC_W'(cam0_reg[i]);
        end
        sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
    end

    logic                rkm_vld;
    logic [SQ_OUT_W-1:0] rkm;

    ccvc_isqrt u_rkm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .radicand  (sum2_reg),
        .out_valid (rkm_vld),
        .root      (rkm)
    );

    // r_draw and the flags that hang on it
    logic [SQ_OUT_W+DSI_W-1:0] rd_prod;
    logic [RD_W-1:0]           rdraw_reg;
    logic                      rdraw_vld_reg;
    logic                      act_dly_reg [ACT_DLY];
    logic                      ok_dly_reg  [OK_DLY];
    logic                      ge_dly_reg  [DIV_LAT];
    logic                      rd_ge;
    logic                      rd_ok;

    assign rd_prod = (SQ_OUT_W+DSI_W)'(rkm) * (SQ_OUT_W+DSI_W)'(dsi_reg);
    assign rd_ge   = {{(RD_W-ED_W){1'b0}}, erad_du_reg} >= rdraw_reg;
    assign rd_ok   = act_dly_reg[ACT_DLY-1] & (rdraw_reg != '0);

    always_ff @(posedge clk)
    begin
        rdraw_reg <= rd_prod[SQ_OUT_W+DSI_W-1:DSI_FRAC];
        act_dly_reg[0] <= act0_reg;
        for (int k = 1; k < ACT_DLY; k++)
            act_dly_reg[k] <= act_dly_reg[k-1];
        ok_dly_reg[0] <= rd_ok;
        for (int k = 1; k < OK_DLY; k++)
            ok_dly_reg[k] <= ok_dly_reg[k-1];
        ge_dly_reg[0] <= rd_ge;
        for (int k = 1; k < DIV_LAT; k++)
            ge_dly_reg[k] <= ge_dly_reg[k-1];
    end

    // ------------------------------------------------------------------
    // cos = erad_du / r_draw (clamped to one), sin = sqrt(1 - cos^2)
    // ------------------------------------------------------------------
    logic               cq_vld;
    logic [DIV_Q_W-1:0] cq;

    ccvc_div u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rdraw_vld_reg),
        .num       (DIV_N_W'({erad_du_reg, {FRAC_BITS{1'b0}}})),
        .den       (DIV_D_W'(rdraw_reg)),
        .out_valid (cq_vld),
        .quo       (cq)
    );

    logic [DIV_Q_W-1:0] cos_reg;
    logic [COS2_W-1:0]  cos2_reg;
    logic [SQ_IN_W-1:0] rad_reg;
    logic               cos_vld_reg;
    logic               cos2_vld_reg;
    logic               rad_vld_reg;

    always_ff @(posedge clk)
    begin
        cos_reg  <= ge_dly_reg[DIV_LAT-1] ? FIX_ONE : cq;
        cos2_reg <= COS2_W'(cos_reg) * COS2_W'(cos_reg);
        rad_reg  <= SQ_IN_W'({1'b1, {(2*FRAC_BITS){1'b0}}}) - SQ_IN_W'(cos2_reg);
    end

    logic                sin_vld;
    logic [SQ_OUT_W-1:0] sin_root;
    logic [SIN_W-1:0]    sin_dly_reg [SIN_DLY];

    ccvc_isqrt u_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_vld_reg),
        .radicand  (rad_reg),
        .out_valid (sin_vld),
        .root      (sin_root)
    );

    always_ff @(posedge clk)
    begin
        sin_dly_reg[0] <= sin_vld ? sin_root[SIN_W-1:0] : '0;
        for (int k = 1; k < SIN_DLY; k++)
            sin_dly_reg[k] <= sin_dly_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Unit vector of the satellite, sub-point, vector camera -> sub-point
    // ------------------------------------------------------------------
    vec_comp_t  sat_vec [3];
    logic       us_vld;
    unit_comp_t us [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sat_vec[i] = VEC_W'(sat0_reg[i]);
    end

    ccvc_unit u_unit_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .vec_in    (sat_vec),
        .out_valid (us_vld),
        .u_out     (us)
    );

    coord_t                   cam_dly_reg [CAM_DLY][3];
    logic signed [PROD_W-1:0] prod_reg    [3];
    vec_comp_t                tosub_reg   [3];
    logic                     prod_vld_reg;
    logic                     tosub_vld_reg;

    always_ff @(posedge clk)
    begin
        cam_dly_reg[0] <= cam0_reg;
        for (int k = 1; k < CAM_DLY; k++)
            cam_dly_reg[k] <= cam_dly_reg[k-1];
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i]  <= $signed({1'b0, erad_du_reg}) * us[i];
            // floor shift back to draw units, then subtract the camera
            tosub_reg[i] <= VEC_W'(prod_reg[i] >>> FRAC_BITS)
                          - VEC_W'(cam_dly_reg[CAM_DLY-1][i]);
        end
    end

    logic       ua_vld;
    unit_comp_t ua [3];

    ccvc_unit u_unit_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tosub_vld_reg),
        .vec_in    (tosub_reg),
        .out_valid (ua_vld),
        .u_out     (ua)
    );

    // Unit vector toward the look point, held until the other one is ready
    logic       ub_vld;
    unit_comp_t ub [3];
    unit_comp_t ub_dly_reg [UB_DLY][3];

    ccvc_unit u_unit_look (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .vec_in    (tolook1_reg),
        .out_valid (ub_vld),
        .u_out     (ub)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            ub_dly_reg[0][i] <= ub_vld ? ub[i] : '0;
        for (int k = 1; k < UB_DLY; k++)
            ub_dly_reg[k] <= ub_dly_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Dot product and the cull test: dot > -sin (both at 2F fraction bits)
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0] mul_reg [3];
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [CMP_W-1:0] dot_ext;
    logic signed [CMP_W-1:0] thr;
    logic                    mul_vld_reg;
    logic                    dot_vld_reg;
    logic                    done_reg;
    logic                    visible_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            mul_reg[i] <= ua[i] * ub_dly_reg[UB_DLY-1][i];
        dot_reg <= DOT_W'(mul_reg[0]) + DOT_W'(mul_reg[1]) + DOT_W'(mul_reg[2]);
    end

    assign dot_ext = CMP_W'(dot_reg);
    assign thr     = -$signed({{(CMP_W-SIN_W-FRAC_BITS){1'b0}},
                               sin_dly_reg[SIN_DLY-1], {FRAC_BITS{1'b0}}});

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rdraw_vld_reg <= 1'b0;
            cos_vld_reg   <= 1'b0;
            cos2_vld_reg  <= 1'b0;
            rad_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            tosub_vld_reg <= 1'b0;
            mul_vld_reg   <= 1'b0;
            dot_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else
        begin
            v0_reg        <= start & ~busy;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            rdraw_vld_reg <= rkm_vld;
            cos_vld_reg   <= cq_vld;
            cos2_vld_reg  <= cos_vld_reg;
            rad_vld_reg   <= cos2_vld_reg;
            prod_vld_reg  <= us_vld;
            tosub_vld_reg <= prod_vld_reg;
            mul_vld_reg   <= ua_vld;
            dot_vld_reg   <= mul_vld_reg;
            done_reg      <= dot_vld_reg;
            visible_reg   <= dot_vld_reg & ok_dly_reg[OK_DLY-1] & (dot_ext > thr);
        end
    end

    assign done    = done_reg;
    assign visible = visible_reg;

endmodule

@@ rtl/ccvc_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, floor(sqrt(radicand)), one root bit per stage.
// Depends on ccvc_pkg.

module ccvc_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ccvc_pkg::SQ_IN_W-1:0]  radicand,
    output logic                          out_valid,
    output logic [ccvc_pkg::SQ_OUT_W-1:0] root
);
    import ccvc_pkg::*;

    localparam int RW = SQ_IN_W + 2;

    logic [RW-1:0]       rem_reg  [SQ_OUT_W-1];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] vld_reg;

    for (genvar s = 0; s < SQ_OUT_W; s++)
    begin : g_stage
        localparam int B = SQ_OUT_W - 1 - s;
        logic [RW-1:0]       rem_in;
        logic [RW-1:0]       test;
        logic [SQ_OUT_W-1:0] root_in;
        logic                vin;
        logic                take;

        if (s == 0)
        begin : g_first
            assign rem_in  = RW'(radicand);
            assign root_in = '0;
            assign vin     = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign vin     = vld_reg[s-1];
        end

        // (root + 2^B)^2 - root^2
        assign test = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
        assign take = rem_in >= test;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vin;
        end

        always_ff @(posedge clk)
        begin
            root_reg[s] <= take ? (root_in | (SQ_OUT_W'(1) << B)) : root_in;
        end

        if (s < SQ_OUT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= take ? (rem_in - test) : rem_in;
            end
        end
    end

    assign out_valid = vld_reg[SQ_OUT_W-1];
    assign root      = root_reg[SQ_OUT_W-1];

endmodule

@@ rtl/ccvc_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ccvc_pkg; quotient must fit in DIV_Q_W bits.

module ccvc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [ccvc_pkg::DIV_N_W-1:0] num,
    input  logic [ccvc_pkg::DIV_D_W-1:0] den,
    output logic                         out_valid,
    output logic [ccvc_pkg::DIV_Q_W-1:0] quo
);
    import ccvc_pkg::*;

    logic [DIV_N_W-1:0] rem_reg [DIV_Q_W-1];
    logic [DIV_D_W-1:0] den_reg [DIV_Q_W-1];
    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W];
    logic [DIV_Q_W-1:0] vld_reg;

    for (genvar s = 0; s < DIV_Q_W; s++)
    begin : g_stage
        localparam int B = DIV_Q_W - 1 - s;
        logic [DIV_N_W-1:0] rem_in;
        logic [DIV_N_W-1:0] test;
        logic [DIV_D_W-1:0] den_in;
        logic [DIV_Q_W-1:0] q_in;
        logic               vin;
        logic               take;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign vin    = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign vin    = vld_reg[s-1];
        end

        assign test = DIV_N_W'(den_in) << B;
        assign take = rem_in >= test;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vin;
        end

        always_ff @(posedge clk)
        begin
            q_reg[s] <= take ? (q_in | (DIV_Q_W'(1) << B)) : q_in;
        end

        if (s < DIV_Q_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= take ? (rem_in - test) : rem_in;
                den_reg[s] <= den_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_Q_W-1];
    assign quo       = q_reg[DIV_Q_W-1];

endmodule

@@ rtl/ccvc_unit.sv @@
`timescale 1ns / 1ps
// Unit-vector pipeline: normalize to [2^29, 2^30), length by square root,
// per-component divide. Depends on ccvc_pkg, ccvc_isqrt, ccvc_div.

module ccvc_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  ccvc_pkg::vec_comp_t    vec_in [3],
    output logic                   out_valid,
    output ccvc_pkg::unit_comp_t   u_out  [3]
);
    import ccvc_pkg::*;

    localparam int POS_W  = $clog2(VEC_W);
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int FLG_DLY = SQRT_LAT + DIV_LAT;

    // stage 1: magnitudes and leading-one position
    logic [VEC_W-1:0] mag [3];
    logic [VEC_W-1:0] mag_or;
    logic [POS_W-1:0] pos;

    logic [VEC_W-1:0] m1_reg [3];
    logic [POS_W-1:0] pos1_reg;
    logic [2:0]       neg1_reg;
    logic             zero1_reg;
    logic             v1_reg;

    always_comb
    begin
        mag_or = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
            mag_or = mag_or | mag[i];
        end
        pos = '0;
        for (int b = 0; b < VEC_W; b++)
        begin
            if (mag_or[b])
                pos = POS_W'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i]   <= mag[i];
            neg1_reg[i] <= vec_in[i][VEC_W-1];
        end
        pos1_reg  <= pos;
        zero1_reg <= (mag_or == '0);
    end

    // stage 2: shift so the largest magnitude has its msb at bit NORM_W-1
    logic [NORM_W-1:0] m2      [3];
    logic [NORM_W-1:0] m2_reg  [3];
    logic [2:0]        neg2_reg;
    logic              zero2_reg;
    logic              v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos1_reg >= POS_W'(NORM_W - 1))
                m2[i] = NORM_W'(m1_reg[i] >> (pos1_reg - POS_W'(NORM_W - 1)));
            else
                m2[i] = NORM_W'(m1_reg[i] << (POS_W'(NORM_W - 1) - pos1_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        m2_reg    <= m2;
        neg2_reg  <= neg1_reg;
        zero2_reg <= zero1_reg;
    end

    // stage 3: squares
    logic [SQ_W-1:0]   sq3_reg [3];
    logic [NORM_W-1:0] m3_reg  [3];
    logic [2:0]        neg3_reg;
    logic              zero3_reg;
    logic              v3_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq3_reg[i] <= SQ_W'(m2_reg[i]) * SQ_W'(m2_reg[i]);
        m3_reg    <= m2_reg;
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
    end

    // stage 4: sum of squares
    logic [SUM_W-1:0]  sum4_reg;
    logic [NORM_W-1:0] m4_reg [3];
    logic [2:0]        neg4_reg;
    logic              zero4_reg;
    logic              v4_reg;

    always_ff @(posedge clk)
    begin
        sum4_reg  <= SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
        m4_reg    <= m3_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // length
    logic                len_vld;
    logic [SQ_OUT_W-1:0] len;

    ccvc_isqrt u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .radicand  (SQ_IN_W'(sum4_reg)),
        .out_valid (len_vld),
        .root      (len)
    );

    // magnitudes wait for the length, sign/zero flags wait for the quotients
    logic [NORM_W-1:0] m_dly_reg [SQRT_LAT][3];
    logic [3:0]        f_dly_reg [FLG_DLY];

    always_ff @(posedge clk)
    begin
        m_dly_reg[0] <= m4_reg;
        for (int k = 1; k < SQRT_LAT; k++)
            m_dly_reg[k] <= m_dly_reg[k-1];
        f_dly_reg[0] <= {zero4_reg, neg4_reg};
        for (int k = 1; k < FLG_DLY; k++)
            f_dly_reg[k] <= f_dly_reg[k-1];
    end

    logic [2:0]         q_vld;
    logic [DIV_Q_W-1:0] q [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        ccvc_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (len_vld),
            .num       (DIV_N_W'({m_dly_reg[SQRT_LAT-1][i], {FRAC_BITS{1'b0}}})),
            .den       (DIV_D_W'(len)),
            .out_valid (q_vld[i]),
            .quo       (q[i])
        );
    end

    // final: apply sign, zero vector gives zero
    logic [3:0]  f_last;
    logic        out_vld_reg;
    unit_comp_t  u_reg [3];

    assign f_last = f_dly_reg[FLG_DLY-1];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (f_last[3])
                u_reg[i] <= '0;
            else if (f_last[i])
                u_reg[i] <= -$signed({1'b0, q[i]});
            else
                u_reg[i] <= $signed({1'b0, q[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= &q_vld;
    end

    assign out_valid = out_vld_reg;
    assign u_out     = u_reg;

endmodule

@@ rtl/ccvc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the coverage-cap visibility cull, bound to the top level.
// Depends on ccvc_pkg.

module ccvc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic sat_active,
    input logic done,
    input logic visible
);
    import ccvc_pkg::*;

    // every result strobe traces back to an earlier input transfer
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY + 1))
        else $error("done without a matching input transfer");

    // every accepted item yields a result after the fixed latency
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##LATENCY done)
        else $error("input transfer produced no result");

    // an inactive satellite is always culled
    a_inactive_culled: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !sat_active) |=> ##LATENCY (done && !visible))
        else $error("inactive satellite reported visible");

    // visible only ever shows alongside the strobe
    a_visible_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !visible)
        else $error("visible high outside a result transfer");

endmodule

bind coverage_cap_visibility_cull ccvc_checker u_ccvc_checker (.*);
